FILE: hdl/lexscan_pkg.sv
// Shared types, token and error codes, and character helpers for the lexical scanner.
// Used by every module of the scanner; depends on nothing else.
package lexscan_pkg;

    localparam int NAME_MAX   = 11;
    localparam int DIGITS_MAX = 5;
    localparam int IDX_W      = $clog2(NAME_MAX);

    // Token codes.
    localparam logic [5:0] TOK_NONE      = 6'd0;
    localparam logic [5:0] TOK_ODD       = 6'd1;
    localparam logic [5:0] TOK_IDENT     = 6'd2;
    localparam logic [5:0] TOK_NUMBER    = 6'd3;
    localparam logic [5:0] TOK_PLUS      = 6'd4;
    localparam logic [5:0] TOK_MINUS     = 6'd5;
    localparam logic [5:0] TOK_TIMES     = 6'd6;
    localparam logic [5:0] TOK_SLASH     = 6'd7;
    localparam logic [5:0] TOK_XOR       = 6'd8;
    localparam logic [5:0] TOK_EQL       = 6'd9;
    localparam logic [5:0] TOK_NEQ       = 6'd10;
    localparam logic [5:0] TOK_LSS       = 6'd11;
    localparam logic [5:0] TOK_LEQ       = 6'd12;
    localparam logic [5:0] TOK_GTR       = 6'd13;
    localparam logic [5:0] TOK_GEQ       = 6'd14;
    localparam logic [5:0] TOK_LPAREN    = 6'd15;
    localparam logic [5:0] TOK_RPAREN    = 6'd16;
    localparam logic [5:0] TOK_COMMA     = 6'd17;
    localparam logic [5:0] TOK_SEMICOLON = 6'd18;
    localparam logic [5:0] TOK_PERIOD    = 6'd19;
    localparam logic [5:0] TOK_BECOMES   = 6'd20;
    localparam logic [5:0] TOK_BEGIN     = 6'd21;
    localparam logic [5:0] TOK_END       = 6'd22;
    localparam logic [5:0] TOK_IF        = 6'd23;
    localparam logic [5:0] TOK_THEN      = 6'd24;
    localparam logic [5:0] TOK_WHILE     = 6'd25;
    localparam logic [5:0] TOK_DO        = 6'd26;
    localparam logic [5:0] TOK_CALL      = 6'd27;
    localparam logic [5:0] TOK_CONST     = 6'd28;
    localparam logic [5:0] TOK_VAR       = 6'd29;
    localparam logic [5:0] TOK_PROCEDURE = 6'd30;
    localparam logic [5:0] TOK_WRITE     = 6'd31;
    localparam logic [5:0] TOK_READ      = 6'd32;
    localparam logic [5:0] TOK_ELSE      = 6'd33;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_SYMBOL = 3'd1;
    localparam logic [2:0] ERR_NAME_LONG  = 3'd2;
    localparam logic [2:0] ERR_NUM_LONG   = 3'd3;
    localparam logic [2:0] ERR_DIGIT_LEAD = 3'd4;

    typedef logic [NAME_MAX-1:0][7:0] t_text;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } t_in_word;

    typedef struct packed {
        logic [5:0]  token_class;
        logic [16:0] number_value;
        logic [3:0]  name_length;
        logic [63:0] name_chars_front;
        logic [23:0] name_chars_back;
        logic [2:0]  error_code;
        logic        run_last;
    } t_out_word;

    // Results of one input word, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_emit;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Single-character symbols; the colon is handled on its own.
    function automatic logic [5:0] sym_code(input logic [7:0] c);
        logic [5:0] code;
        case (c)
            "+":     code = TOK_PLUS;
            "-":     code = TOK_MINUS;
            "*":     code = TOK_TIMES;
            "/":     code = TOK_SLASH;
            "(":     code = TOK_LPAREN;
            ")":     code = TOK_RPAREN;
            "=":     code = TOK_EQL;
            ",":     code = TOK_COMMA;
            ".":     code = TOK_PERIOD;
            "<":     code = TOK_LSS;
            ">":     code = TOK_GTR;
            ";":     code = TOK_SEMICOLON;
            default: code = TOK_NONE;
        endcase
        return code;
    endfunction

    // Packs the first n characters right-justified, so the key compares
    // directly against string literals. No reserved word is longer than nine.
    function automatic logic [5:0] kw_lookup(input t_text t, input logic [3:0] n);
        logic [71:0] key;
        logic [5:0]  code;
        key  = '0;
        code = TOK_IDENT;
        for (int i = 0; i < 9; i++) begin
            if (4'(i) < n) begin
                key = {key[63:0], t[i]};
            end
        end
        if (n <= 4'd9) begin
            unique case (key)
                72'("const"):     code = TOK_CONST;
                72'("var"):       code = TOK_VAR;
                72'("procedure"): code = TOK_PROCEDURE;
                72'("call"):      code = TOK_CALL;
                72'("begin"):     code = TOK_BEGIN;
                72'("end"):       code = TOK_END;
                72'("if"):        code = TOK_IF;
                72'("then"):      code = TOK_THEN;
                72'("xor"):       code = TOK_XOR;
                72'("else"):      code = TOK_ELSE;
                72'("while"):     code = TOK_WHILE;
                72'("do"):        code = TOK_DO;
                72'("read"):      code = TOK_READ;
                72'("write"):     code = TOK_WRITE;
                72'("odd"):       code = TOK_ODD;
                default:          code = TOK_IDENT;
            endcase
        end
        return code;
    endfunction

endpackage

FILE: hdl/lexscan_core.sv
// Scanner state and the single-pass logic that turns one character into up to two results.
// Depends on lexscan_pkg.
module lexscan_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  lexscan_pkg::t_in_word i_word,
    output lexscan_pkg::t_emit    o_emit
);

    typedef enum logic [2:0] {
        S_START,
        S_IDENT,
        S_NUM,
        S_LESS,
        S_GTR,
        S_COLON,
        S_SYM
    } t_mode;

    t_mode               r_mode, p_mode, n_mode;
    logic [5:0]          r_sym, p_sym;
    lexscan_pkg::t_text  r_text, p_text;
    logic [3:0]          r_count, p_count, n_count;
    logic [16:0]         r_value, p_value, n_value;
    logic                r_halted;

    logic [7:0]             c;
    logic                   eos;
    logic                   alpha, digit, space, colon, ch_ok;
    logic [5:0]             sym;
    logic                   emit_a, emit_c, do_start, wr_en;
    logic [lexscan_pkg::IDX_W-1:0] wr_idx;
    logic [2:0]             err;
    lexscan_pkg::t_out_word tok_a, tok_c, err_word, second;
    logic                   has2;

    function automatic lexscan_pkg::t_out_word build_token(
        input t_mode              m,
        input logic [5:0]         s,
        input lexscan_pkg::t_text t,
        input logic [3:0]         n,
        input logic [16:0]        v
    );
        lexscan_pkg::t_out_word w;
        logic [5:0]             code;
        w    = '0;
        code = lexscan_pkg::kw_lookup(t, n);
        case (m)
            S_IDENT: begin
                w.token_class = code;
                if (code == lexscan_pkg::TOK_IDENT) begin
                    w.name_length = n;
                    for (int i = 0; i < 8; i++) begin
                        if (4'(i) < n) begin
                            w.name_chars_front[8*i +: 8] = t[i];
                        end
                    end
                    for (int j = 0; j < lexscan_pkg::NAME_MAX - 8; j++) begin
                        if (4'(j + 8) < n) begin
                            w.name_chars_back[8*j +: 8] = t[j+8];
                        end
                    end
                end
            end
            S_NUM: begin
                w.token_class  = lexscan_pkg::TOK_NUMBER;
                w.number_value = v;
            end
            S_LESS:  w.token_class = lexscan_pkg::TOK_LSS;
            S_GTR:   w.token_class = lexscan_pkg::TOK_GTR;
            S_SYM:   w.token_class = s;
            default: w.token_class = lexscan_pkg::TOK_NONE;
        endcase
        return w;
    endfunction

    assign c     = i_word.ch;
    assign eos   = i_word.end_of_source;
    assign alpha = lexscan_pkg::is_alpha(c);
    assign digit = lexscan_pkg::is_digit(c);
    assign space = lexscan_pkg::is_space(c);
    assign colon = (c == ":");
    assign sym   = lexscan_pkg::sym_code(c);
    assign ch_ok = alpha || digit || space || colon || (sym != lexscan_pkg::TOK_NONE);

    always_comb begin
        p_mode   = r_mode;
        p_sym    = r_sym;
        p_count  = r_count;
        p_value  = r_value;
        emit_a   = 1'b0;
        emit_c   = 1'b0;
        do_start = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = '0;
        err      = lexscan_pkg::ERR_NONE;

        if (!ch_ok) begin
            err = lexscan_pkg::ERR_BAD_SYMBOL;
        end else begin
            unique case (r_mode)
                S_START: do_start = 1'b1;
                S_IDENT: begin
                    if (alpha || digit) begin
                        if (r_count >= 4'(lexscan_pkg::NAME_MAX)) begin
                            err = lexscan_pkg::ERR_NAME_LONG;
                        end else begin
                            wr_en   = 1'b1;
                            wr_idx  = r_count[lexscan_pkg::IDX_W-1:0];
                            p_count = r_count + 4'd1;
                        end
                    end else begin
                        emit_a   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                S_NUM: begin
                    if (digit) begin
                        if (r_count >= 4'(lexscan_pkg::DIGITS_MAX)) begin
                            err = lexscan_pkg::ERR_NUM_LONG;
                        end else begin
                            p_count = r_count + 4'd1;
                            p_value = r_value * 17'd10 + {13'd0, c[3:0]};
                        end
                    end else if (alpha) begin
                        err = lexscan_pkg::ERR_DIGIT_LEAD;
                    end else begin
                        emit_a   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                S_LESS: begin
                    if (c == ">") begin
                        p_mode = S_SYM;
                        p_sym  = lexscan_pkg::TOK_NEQ;
                    end else if (c == "=") begin
                        p_mode = S_SYM;
                        p_sym  = lexscan_pkg::TOK_LEQ;
                    end else begin
                        emit_a   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                S_GTR: begin
                    if (c == "=") begin
                        p_mode = S_SYM;
                        p_sym  = lexscan_pkg::TOK_GEQ;
                    end else begin
                        emit_a   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                S_COLON: begin
                    if (c == "=") begin
                        p_mode = S_SYM;
                        p_sym  = lexscan_pkg::TOK_BECOMES;
                    end else begin
                        err = lexscan_pkg::ERR_BAD_SYMBOL;
                    end
                end
                S_SYM: begin
                    emit_a   = 1'b1;
                    do_start = 1'b1;
                end
                default: p_mode = S_START;
            endcase
        end

        // The terminating character is scanned again from the start state.
        if (do_start) begin
            p_mode  = S_START;
            p_count = 4'd0;
            p_value = '0;
            if (alpha) begin
                p_mode  = S_IDENT;
                wr_en   = 1'b1;
                wr_idx  = '0;
                p_count = 4'd1;
            end else if (digit) begin
                p_mode  = S_NUM;
                p_count = 4'd1;
                p_value = {13'd0, c[3:0]};
            end else if (colon && eos) begin
                err = lexscan_pkg::ERR_BAD_SYMBOL;
            end else if (colon) begin
                p_mode = S_COLON;
            end else if (c == "<") begin
                p_mode = S_LESS;
            end else if (c == ">") begin
                p_mode = S_GTR;
            end else if (!space) begin
                p_mode = S_SYM;
                p_sym  = sym;
            end
        end

        for (int i = 0; i < lexscan_pkg::NAME_MAX; i++) begin
            p_text[i] = (wr_en && wr_idx == lexscan_pkg::IDX_W'(i)) ? c : r_text[i];
        end

        n_mode  = p_mode;
        n_count = p_count;
        n_value = p_value;
        // End of source flushes whatever the character left pending.
        if (eos && err == lexscan_pkg::ERR_NONE) begin
            if (p_mode == S_COLON) begin
                err = lexscan_pkg::ERR_BAD_SYMBOL;
            end else begin
                emit_c = (p_mode != S_START);
            end
            n_mode  = S_START;
            n_count = 4'd0;
            n_value = '0;
        end
    end

    assign tok_a = build_token(r_mode, r_sym, r_text, r_count, r_value);
    assign tok_c = build_token(p_mode, p_sym, p_text, p_count, p_value);

    always_comb begin
        err_word            = '0;
        err_word.error_code = err;
    end

    assign second = (err != lexscan_pkg::ERR_NONE) ? err_word : tok_c;
    assign has2   = (err != lexscan_pkg::ERR_NONE) || emit_c;

    always_comb begin
        o_emit = '0;
        if (i_valid && !r_halted) begin
            if (emit_a) begin
                o_emit.first  = tok_a;
                o_emit.second = second;
                o_emit.count  = has2 ? 2'd2 : 2'd1;
            end else begin
                o_emit.first  = second;
                o_emit.count  = has2 ? 2'd1 : 2'd0;
            end
            if (o_emit.count == 2'd2) begin
                o_emit.second.run_last = 1'b1;
            end else begin
                o_emit.first.run_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_START;
            r_sym    <= lexscan_pkg::TOK_NONE;
            r_count  <= 4'd0;
            r_value  <= '0;
            r_halted <= 1'b0;
        end else if (i_valid && !r_halted) begin
            r_mode   <= n_mode;
            r_sym    <= p_sym;
            r_count  <= n_count;
            r_value  <= n_value;
            r_text   <= p_text;
            r_halted <= (err != lexscan_pkg::ERR_NONE);
        end
    end

endmodule

FILE: hdl/lexscan_result_fifo.sv
// Four-entry result queue: takes up to two results a cycle, delivers one a cycle while the reader is ready.
// Depends on lexscan_pkg.
module lexscan_result_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lexscan_pkg::t_emit     i_emit,
    output logic                   o_room,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lexscan_pkg::t_out_word o_word
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    lexscan_pkg::t_out_word r_mem [DEPTH];
    logic [PTR_W-1:0]       r_head;
    logic [PTR_W:0]         r_count;
    logic [PTR_W-1:0]       tail;
    logic                   pop;

    assign tail    = r_head + r_count[PTR_W-1:0];
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_head];
    // Room for a full pair of results, whatever the reader does this cycle.
    assign o_room  = (r_count <= (PTR_W+1)'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[tail] <= i_emit.first;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[tail + PTR_W'(1)] <= i_emit.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + PTR_W'(pop);
            r_count <= r_count + (PTR_W+1)'(i_emit.count) - (PTR_W+1)'(pop);
        end
    end

endmodule

FILE: hdl/pl0_lexical_scanner_top.sv
// Top level of the character-serial lexical scanner.
// Depends on lexscan_pkg, lexscan_core and lexscan_result_fifo.
//
// Input channel: one source character per word (ch, end_of_source) on
// i_in_valid / o_in_ready / i_in_word. Output channel: one token or error
// result per word on o_out_valid / i_out_ready / o_out_word; run_last marks
// the final result caused by a character.
//
// A character is held in an input register and scanned by the core once the
// result queue has room; its results land in a four-entry result queue and
// are offered on the output channel from there. One character is taken every
// cycle while the queue has room; a character that yields two results (a
// token ended by a symbol that is itself flushed, or a token followed by an
// error) occupies the output port for two result words, which is the limit on
// sustained rate. The queue takes a character only when it has room for two
// results.
//
// Reset (synchronous, active low) returns the scanner to its start state,
// clears any halt after an error and empties the queue. When the receiver
// stalls, the queue fills, then the input register holds and o_in_ready
// drops; nothing is lost. After an error result the block keeps taking
// characters but produces nothing until reset.
module pl0_lexical_scanner_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lexscan_pkg::t_in_word  i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output lexscan_pkg::t_out_word o_out_word
);

    logic                  r_in_valid;
    lexscan_pkg::t_in_word r_in_word;
    logic                  room;
    logic                  process;
    lexscan_pkg::t_emit    emit;

    assign process    = r_in_valid && room;
    assign o_in_ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    lexscan_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (process),
        .i_word  (r_in_word),
        .o_emit  (emit)
    );

    lexscan_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

FILE: hdl/lexscan_checker.sv
// Port-level checks for the lexical scanner, bound to the top level.
// Depends on lexscan_pkg and pl0_lexical_scanner_top.
module lexscan_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input lexscan_pkg::t_out_word o_out_word
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // An error is always the final result until the next reset.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_word.error_code != lexscan_pkg::ERR_NONE
        |=> !o_out_valid)
        else $error("result delivered after an error");

    // An error result carries nothing else and ends its character's run.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.error_code != lexscan_pkg::ERR_NONE
        |-> o_out_word.token_class == lexscan_pkg::TOK_NONE
            && o_out_word.name_length == 4'd0 && o_out_word.run_last)
        else $error("malformed error result");

    // Name text appears only on plain identifiers, within the length limit.
    a_ident_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.name_length != 4'd0
        |-> o_out_word.token_class == lexscan_pkg::TOK_IDENT
            && o_out_word.name_length <= 4'(lexscan_pkg::NAME_MAX))
        else $error("name length on a non-identifier result");

    // Leaving reset, the queue is empty and the input side is open.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("scanner not clear after reset");

endmodule

bind pl0_lexical_scanner_top lexscan_checker u_checker (.*);
